// ----- hdl/rounded_corner_pixel_mask_top_macros.svh -----
// Assertion macros shared by the corner mask modules.
// Each use expects clk and rst_n in scope.
`ifndef ROUNDED_CORNER_PIXEL_MASK_TOP_MACROS_SVH
`define ROUNDED_CORNER_PIXEL_MASK_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RCPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RCPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RCPM_ASSERT_IMP(lbl, ante, cons, msg)
`define RCPM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/rcpm_pkg.sv -----
`timescale 1ns / 1ps
package rcpm_pkg;

  localparam int SideBits = 10;
  localparam logic [9:0] SideMask = 10'((1 << SideBits) - 1);
  localparam logic [3:0] MaxRadius = 4'd12;

  // one root bit per cell: radicand is the 8-bit sum of squares shifted up 16
  localparam int NumSteps = 12;
  localparam int RootW = NumSteps;
  localparam int RemW = RootW + 2;

  localparam logic [1:0] CfgImageSide = 2'd0;
  localparam logic [1:0] CfgCornerRadius = 2'd1;
  localparam logic [1:0] CfgBackground = 2'd2;

  localparam logic [1:0] CovPass = 2'd0;
  localparam logic [1:0] CovBlend = 2'd1;
  localparam logic [1:0] CovBackground = 2'd2;

  localparam logic [9:0] SideReset = 10'd64;

  typedef struct packed {
    logic [9:0]  pixel_row;
    logic [9:0]  pixel_col;
    logic [15:0] pixel_in;
  } rcpm_in_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic [1:0]  coverage_class;
  } rcpm_out_t;

  typedef struct packed {
    logic [9:0]  side;
    logic [3:0]  rad;
    logic [15:0] bg;
  } rcpm_cfg_t;

  // item moving along the root chain
  typedef struct packed {
    logic [15:0]     pix;
    logic [7:0]      sumsq;
    logic            bypass;
    logic [RootW-1:0] root;
    logic [RemW-1:0]  rem;
  } rcpm_sq_t;

  function automatic logic [7:0] widen5(logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] x);
    return {x, x[5:4]};
  endfunction

  // src + (dst - src) * t / 256, division truncating toward zero
  function automatic logic [7:0] mix_channel(logic [7:0] src, logic [7:0] dst,
                                             logic [7:0] t);
    logic signed [8:0]  d;
    logic signed [17:0] p;
    logic signed [17:0] a;
    logic [7:0]         qv;
    d  = $signed({1'b0, dst}) - $signed({1'b0, src});
    p  = d * $signed({1'b0, t});
    a  = p + (p[17] ? 18'sd255 : 18'sd0);
    qv = 8'(a >>> 8);
    return src + qv;
  endfunction

endpackage

// ----- hdl/rcpm_front.sv -----
`timescale 1ns / 1ps
module rcpm_front
  import rcpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rcpm_cfg_t  cfg,
  input  logic       up_valid,
  output logic       up_ready,
  input  rcpm_in_t   up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output rcpm_sq_t   dn_data
);

  logic       valid_r, valid_nxt;
  rcpm_sq_t   data_r, data_nxt;

  logic [9:0] row, col, side;
  logic       near_r, near_c, far_r, far_c, band_r, band_c, in_image;
  logic [9:0] m_row, m_col;
  logic [3:0] rr, rc;
  logic [7:0] sq_r, sq_c;

  always_comb begin
    row  = up_data.pixel_row & SideMask;
    col  = up_data.pixel_col & SideMask;
    side = cfg.side & SideMask;

    in_image = (cfg.rad != 4'd0) && (row < side) && (col < side);

    // mirror into the top-left corner; near edge wins where bands overlap
    near_r = row < {6'd0, cfg.rad};
    near_c = col < {6'd0, cfg.rad};
    far_r  = ({1'b0, row} + {7'd0, cfg.rad}) >= {1'b0, side};
    far_c  = ({1'b0, col} + {7'd0, cfg.rad}) >= {1'b0, side};
    band_r = near_r || far_r;
    band_c = near_c || far_c;
    m_row  = near_r ? row : side - 10'd1 - row;
    m_col  = near_c ? col : side - 10'd1 - col;

    rr   = cfg.rad - 4'd1 - m_row[3:0];
    rc   = cfg.rad - 4'd1 - m_col[3:0];
    sq_r = {4'd0, rr} * {4'd0, rr};
    sq_c = {4'd0, rc} * {4'd0, rc};

    data_nxt.pix    = up_data.pixel_in;
    data_nxt.sumsq  = sq_r + sq_c;
    data_nxt.bypass = !(in_image && band_r && band_c);
    data_nxt.root   = '0;
    data_nxt.rem    = '0;
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- hdl/rcpm_sqrt_cell.sv -----
`timescale 1ns / 1ps
`include "rounded_corner_pixel_mask_top_macros.svh"
module rcpm_sqrt_cell
  import rcpm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  rcpm_sq_t  up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output rcpm_sq_t  dn_data
);

  localparam int PairHi = 2 * (NumSteps - 1 - STEP) + 1;

  logic               valid_r, valid_nxt;
  rcpm_sq_t           data_r, data_nxt;
  logic [2*NumSteps-1:0] radicand;
  logic [1:0]         pair;
  logic [RemW-1:0]    rem_sh, trial;
  logic               take;

  always_comb begin
    radicand = {up_data.sumsq, {(2 * NumSteps - 8){1'b0}}};
    pair     = radicand[PairHi -: 2];
    // remainder never exceeds twice the partial root, so top bits are clear
    rem_sh   = {up_data.rem[RemW-3:0], pair};
    trial    = {up_data.root, 2'b01};
    take     = rem_sh >= trial;

    data_nxt      = up_data;
    data_nxt.rem  = take ? rem_sh - trial : rem_sh;
    data_nxt.root = {up_data.root[RootW-2:0], take};
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  `RCPM_ASSERT_IMP(a_rem_bound, valid_r, data_r.rem <= RemW'({data_r.root, 1'b0}), "root remainder out of range")

endmodule

// ----- hdl/rcpm_blend.sv -----
`timescale 1ns / 1ps
`include "rounded_corner_pixel_mask_top_macros.svh"
module rcpm_blend
  import rcpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rcpm_cfg_t cfg,
  input  logic      up_valid,
  output logic      up_ready,
  input  rcpm_sq_t  up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output rcpm_out_t dn_data
);

  logic        valid_r, valid_nxt;
  rcpm_out_t   data_r, data_nxt;

  logic [12:0] dist_fx, r256, lo, hi;
  logic [7:0]  t;
  logic [7:0]  mr, mg, mb;

  always_comb begin
    dist_fx = {1'b0, up_data.root};
    r256    = {1'b0, cfg.rad, 8'h00};
    lo      = r256 - 13'd128;
    hi      = r256 + 13'd128;
    t       = 8'(dist_fx - lo);

    mr = mix_channel(widen5(up_data.pix[15:11]), widen5(cfg.bg[15:11]), t);
    mg = mix_channel(widen6(up_data.pix[10:5]), widen6(cfg.bg[10:5]), t);
    mb = mix_channel(widen5(up_data.pix[4:0]), widen5(cfg.bg[4:0]), t);

    if (up_data.bypass || dist_fx <= lo) begin
      data_nxt.pixel_out      = up_data.pix;
      data_nxt.coverage_class = CovPass;
    end else if (dist_fx >= hi) begin
      data_nxt.pixel_out      = cfg.bg;
      data_nxt.coverage_class = CovBackground;
    end else begin
      data_nxt.pixel_out      = {mr[7:3], mg[7:2], mb[7:3]};
      data_nxt.coverage_class = CovBlend;
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  `RCPM_ASSERT_IMP(a_bg_colour, valid_r && data_r.coverage_class == CovBackground, data_r.pixel_out == cfg.bg, "background item carries wrong colour")

endmodule

// ----- hdl/rounded_corner_pixel_mask_top.sv -----
`timescale 1ns / 1ps
`include "rounded_corner_pixel_mask_top_macros.svh"
// channel   ports                          moves
// in        in_valid / in_ready / in_data  pixel row, column and colour
// out       out_valid / out_ready / out_data  masked colour and class
// cfg       cfg_we / cfg_index / cfg_wdata  register write, no wait
//
// One item per cycle sustained while out_ready holds; the stages are the corner fold and squares,
// twelve root cells (one root bit each), then the blend and output register.
// Each cell has its own ready, so bubbles close up under a stalled output.
// Synchronous active-low reset empties every cell and loads register defaults.

module rounded_corner_pixel_mask_top
  import rcpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  rcpm_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rcpm_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [9:0]  image_side_r;
  logic [3:0]  corner_radius_r;
  logic [15:0] background_r;
  rcpm_cfg_t   cfg;

  rcpm_sq_t    sq_data [NumSteps+1];
  logic [NumSteps:0] sq_valid;
  logic [NumSteps:0] sq_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_side_r    <= SideReset;
      corner_radius_r <= 4'd0;
      background_r    <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgImageSide:    image_side_r    <= cfg_wdata[9:0];
        CfgCornerRadius: corner_radius_r <= cfg_wdata[3:0];
        CfgBackground:   background_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.side = image_side_r;
    cfg.rad  = (corner_radius_r > MaxRadius) ? MaxRadius : corner_radius_r;
    cfg.bg   = background_r;
  end

  rcpm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (sq_valid[0]),
    .dn_ready (sq_ready[0]),
    .dn_data  (sq_data[0])
  );

  for (genvar i = 0; i < NumSteps; i++) begin : g_root
    rcpm_sqrt_cell #(
      .STEP (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_valid[i]),
      .up_ready (sq_ready[i]),
      .up_data  (sq_data[i]),
      .dn_valid (sq_valid[i+1]),
      .dn_ready (sq_ready[i+1]),
      .dn_data  (sq_data[i+1])
    );
  end

  rcpm_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (sq_valid[NumSteps]),
    .up_ready (sq_ready[NumSteps]),
    .up_data  (sq_data[NumSteps]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

  // input can only back up when every cell is full and the output is held
  `RCPM_ASSERT_IMP(a_full_when_blocked, !in_ready, out_valid && !out_ready && (&sq_valid), "input blocked with room in the chain")
  `RCPM_ASSERT_NXT(a_accept_lands, in_valid && in_ready, sq_valid[0], "accepted item missing from front cell")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import rcpm_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  rcpm_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  rcpm_out_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // shadow copies of the configuration registers
  logic [9:0]  side_q;
  logic [3:0]  rad_q;
  logic [15:0] bg_q;

  rcpm_out_t expected_pixels[$];
  int        mismatch_count;
  int        cycle_count;
  bit        gaps_on;
  bit        stalls_on;
  bit        hold_req;

  rounded_corner_pixel_mask_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned root_8p8(int unsigned sumsq);
    longint unsigned x;
    longint unsigned res;
    longint unsigned cand;
    x = longint'(sumsq) << 16;
    res = 0;
    for (int b = 15; b >= 0; b--) begin
      cand = res | (longint'(1) << b);
      if (cand * cand <= x) res = cand;
    end
    return int'(res);
  endfunction

  // mirror a coordinate into the near corner band, near edge taking priority
  function automatic bit fold_coord(int p, int side, int rad, output int m);
    m = 0;
    if (p < rad) begin
      m = p;
      return 1'b1;
    end
    if (p + rad >= side) begin
      m = side - 1 - p;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] blend_channel(logic [7:0] src, logic [7:0] dst, int t);
    int d;
    int v;
    d = int'(dst) - int'(src);
    v = int'(src) + (d * t) / 256;
    return v[7:0];
  endfunction

  function automatic logic [15:0] blend_colour(logic [15:0] src, logic [15:0] dst, int t);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = blend_channel({src[15:11], src[15:13]}, {dst[15:11], dst[15:13]}, t);
    g = blend_channel({src[10:5], src[10:9]}, {dst[10:5], dst[10:9]}, t);
    b = blend_channel({src[4:0], src[4:2]}, {dst[4:0], dst[4:2]}, t);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic rcpm_out_t mask_pixel(rcpm_in_t px);
    rcpm_out_t res;
    int row;
    int col;
    int side;
    int rad;
    int mr;
    int mc;
    int rr;
    int rc;
    int dist_fx;
    int r256;
    row = int'(px.pixel_row);
    col = int'(px.pixel_col);
    side = int'(side_q);
    rad = (rad_q > MaxRadius) ? int'(MaxRadius) : int'(rad_q);
    res.pixel_out = px.pixel_in;
    res.coverage_class = CovPass;
    if (rad == 0 || row >= side || col >= side) return res;
    if (!fold_coord(row, side, rad, mr) || !fold_coord(col, side, rad, mc)) return res;
    rr = rad - 1 - mr;
    rc = rad - 1 - mc;
    dist_fx = int'(root_8p8(rr * rr + rc * rc));
    r256 = rad * 256;
    if (dist_fx <= r256 - 128) return res;
    if (dist_fx >= r256 + 128) begin
      res.pixel_out = bg_q;
      res.coverage_class = CovBackground;
      return res;
    end
    res.pixel_out = blend_colour(px.pixel_in, bg_q, dist_fx - (r256 - 128));
    res.coverage_class = CovBlend;
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    rcpm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected item", 16'h0, out_data.pixel_out);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.pixel_out !== want.pixel_out)
          report_mismatch("pixel_out", want.pixel_out, out_data.pixel_out);
        if (out_data.coverage_class !== want.coverage_class)
          report_mismatch("coverage_class", 16'(want.coverage_class),
                          16'(out_data.coverage_class));
      end
    end
  end

  // ---------------------------------------------------------------- sides

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && stalls_on && $urandom_range(0, 99) < 12) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input rcpm_in_t px);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < 25) gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(mask_pixel(px));
  endtask

  function automatic rcpm_in_t make_pixel(int row, int col, logic [15:0] colour);
    rcpm_in_t px;
    px.pixel_row = row[9:0];
    px.pixel_col = col[9:0];
    px.pixel_in = colour;
    return px;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgImageSide:    side_q = val[9:0];
      CfgCornerRadius: rad_q = val[3:0];
      CfgBackground:   bg_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] side_w, logic [15:0] rad_w, logic [15:0] bg_w);
    wait_idle();
    write_reg(CfgImageSide, side_w);
    write_reg(CfgCornerRadius, rad_w);
    write_reg(CfgBackground, bg_w);
  endtask

  // bias coordinates towards the corner bands
  function automatic int pick_coord(int side, int rad);
    int sel;
    int off;
    sel = $urandom_range(0, 9);
    if (side == 0 || sel == 9) return $urandom_range(0, 1023);
    off = $urandom_range(0, rad);
    if (sel < 4) return (off < side) ? off : 0;
    if (sel < 8) return (side - 1 - off >= 0) ? side - 1 - off : 0;
    return $urandom_range(0, side - 1);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    // radius is zero after reset, so even the corners pass
    send_pixel(make_pixel(0, 0, 16'habcd));
    send_pixel(make_pixel(63, 63, 16'h5432));
  endtask

  task automatic test_corner_edges();
    // side written with junk above bit 9: still 64
    set_config(16'hfc40, 16'd4, 16'h0000);
    send_pixel(make_pixel(0, 0, 16'hffff));
    send_pixel(make_pixel(0, 1, 16'hffff));
    send_pixel(make_pixel(1, 1, 16'hffff));
    send_pixel(make_pixel(3, 3, 16'hffff));
    send_pixel(make_pixel(63, 63, 16'hf81f));
    send_pixel(make_pixel(0, 63, 16'h07e0));
    send_pixel(make_pixel(63, 0, 16'h001f));
    send_pixel(make_pixel(64, 0, 16'hffff));
    send_pixel(make_pixel(1023, 1023, 16'hffff));
    send_pixel(make_pixel(32, 32, 16'h1234));
  endtask

  task automatic test_radius_saturation_overlap();
    // radius above the maximum with corners overlapping on a small image, then a zero side
    set_config(16'd16, 16'hfff, 16'hffff);
    send_pixel(make_pixel(0, 0, 16'h0000));
    send_pixel(make_pixel(5, 10, 16'h0000));
    send_pixel(make_pixel(10, 5, 16'h8410));
    send_pixel(make_pixel(15, 15, 16'h0000));
    set_config(16'd0, 16'd12, 16'hffff);
    send_pixel(make_pixel(0, 0, 16'h1234));
  endtask

  task automatic test_large_image();
    set_config(16'd1023, 16'd1, 16'h5555);
    send_pixel(make_pixel(0, 0, 16'haaaa));
    send_pixel(make_pixel(1022, 1022, 16'haaaa));
    send_pixel(make_pixel(1022, 500, 16'haaaa));
  endtask

  task automatic test_random_sweep();
    int side;
    int rad;
    int sel;
    for (int phase = 0; phase < 10; phase++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       side = $urandom_range(1, 3);
        1:       side = 1023;
        2:       side = 0;
        9:       side = $urandom_range(41, 1023);
        default: side = $urandom_range(4, 40);
      endcase
      rad = $urandom_range(0, 15);
      set_config({6'($urandom_range(0, 63)), side[9:0]},
                 {12'($urandom_range(0, 4095)), rad[3:0]},
                 16'($urandom_range(0, 65535)));
      gaps_on = (phase != 3);
      stalls_on = (phase != 3);
      if (rad > 12) rad = 12;
      repeat (50) begin
        send_pixel(make_pixel(pick_coord(side, rad), pick_coord(side, rad),
                              16'($urandom_range(0, 65535))));
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    set_config(16'd24, 16'd10, 16'h07e0);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (80) begin
      send_pixel(make_pixel(pick_coord(24, 10), pick_coord(24, 10),
                            16'($urandom_range(0, 65535))));
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CfgImageSide;
    cfg_wdata = '0;
    side_q = SideReset;
    rad_q = 4'd0;
    bg_q = 16'h0000;
    mismatch_count = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_corner_edges();
    test_radius_saturation_overlap();
    test_large_image();
    test_output_backpressure();
    test_random_sweep();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rcpm_pkg.sv
hdl/rcpm_front.sv
hdl/rcpm_sqrt_cell.sv
hdl/rcpm_blend.sv
hdl/rounded_corner_pixel_mask_top.sv
tb/sv/testbench.sv
